FILE: design/polyphase_fir_interpolator_core_defines.svh
// ---------------------------------------------------------------------------
// Polyphase FIR interpolator assertion macros
// Shared property shorthands, sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef POLYPHASE_FIR_INTERPOLATOR_CORE_DEFINES_SVH
`define POLYPHASE_FIR_INTERPOLATOR_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define PFI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define PFI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pfi_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfi_pkg
// Shared widths, defaults and codes of the polyphase FIR interpolator.
// ---------------------------------------------------------------------------
package pfi_pkg;

    localparam int DATA_W        = 32;
    localparam int PHASE_FIELD_W = 3;
    localparam int TAP_FIELD_W   = 4;

    localparam int DEF_PHASES = 8;
    localparam int DEF_TAPS   = 16;

    // divide by 32768 toward zero: bias negatives, then arithmetic shift
    localparam int                Q15_SHIFT = 15;
    localparam logic [DATA_W-1:0] Q15_BIAS  = DATA_W'((1 << Q15_SHIFT) - 1);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } opcode_t;

endpackage

FILE: design/pfi_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfi_in_if
// Input channel: coefficient loads and source samples.
// ---------------------------------------------------------------------------
interface pfi_in_if;
    import pfi_pkg::*;

    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic        [PHASE_FIELD_W-1:0] coef_phase;
    logic        [TAP_FIELD_W-1:0]   coef_tap;
    logic signed [DATA_W-1:0]        coef_value;
    logic signed [DATA_W-1:0]        sample_value;
    logic                            end_of_frame;

    modport source (
        output valid, opcode, coef_phase, coef_tap, coef_value, sample_value,
               end_of_frame,
        input  ready
    );

    modport sink (
        input  valid, opcode, coef_phase, coef_tap, coef_value, sample_value,
               end_of_frame,
        output ready
    );

endinterface

FILE: design/pfi_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfi_out_if
// Output channel: one interpolated sample per word.
// ---------------------------------------------------------------------------
interface pfi_out_if;
    import pfi_pkg::*;

    logic                            valid;
    logic                            ready;
    logic signed [DATA_W-1:0]        out_sample;
    logic        [PHASE_FIELD_W-1:0] out_phase;
    logic                            last_of_run;
    logic                            last_of_frame;

    modport source (
        output valid, out_sample, out_phase, last_of_run, last_of_frame,
        input  ready
    );

    modport sink (
        input  valid, out_sample, out_phase, last_of_run, last_of_frame,
        output ready
    );

endinterface

FILE: design/polyphase_fir_interpolator_core.sv
`timescale 1ns / 1ps
// Load word: taken while idle; ready stays high after it.
// Sample word that completes the window: a run over every tap of every phase
// on the single multiply-accumulate (one tap per cycle out of the coefficient
// and window RAMs, while the output is not stalled); ready stays low for the run.
// Each phase gives one result word, through RAM read, product, sum and output registers.
// Reset clears control and window fill; coefficient RAM is not cleared.
// ---------------------------------------------------------------------------
// polyphase_fir_interpolator_core
// Polyphase FIR interpolator with RAM-held coefficients and sample window.
// ---------------------------------------------------------------------------
module polyphase_fir_interpolator_core #(
    parameter int PHASES = pfi_pkg::DEF_PHASES,
    parameter int TAPS   = pfi_pkg::DEF_TAPS
) (
    input  logic     clk,
    input  logic     rst_n,
    pfi_in_if.sink   feed,
    pfi_out_if.source result
);
    import pfi_pkg::*;

    localparam int PW     = $clog2(PHASES);
    localparam int TW     = $clog2(TAPS);
    localparam int CW     = $clog2(TAPS + 1);
    localparam int CDEPTH = PHASES * (2 ** TW);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    typedef struct packed {
        logic [PW-1:0] phase;
        logic          first;
        logic          last;
        logic          eof;
    } tag_t;

    function automatic logic [TW-1:0] ptr_inc(input logic [TW-1:0] p);
        return (p == TW'(TAPS - 1)) ? '0 : p + 1'b1;
    endfunction

    state_t        state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [TW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [TW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic [TW-1:0] ctap_reg, ctap_next;
    logic          eof_reg, eof_next;

    logic          s1_vld_reg, s2_vld_reg, s3_vld_reg;
    tag_t          s1_tag_reg, s2_tag_reg, s3_tag_reg;
    tag_t          tag0;
    logic [DATA_W-1:0] prod_reg, acc_reg, sum_reg;
    logic [DATA_W-1:0] acc_sum, bias_sum, quot;

    logic              out_vld_reg;
    logic [DATA_W-1:0] out_sample_reg;
    logic [PW-1:0]     out_phase_reg;
    logic              out_last_reg, out_eof_reg;

    logic accept, is_load, is_push, ld_ok, adv, issue, full_after;
    logic [CW-1:0] fill_inc;
    logic [DATA_W-1:0] coef_rdata, win_rdata;

    assign feed.ready = (state_reg == ST_IDLE);
    assign accept     = feed.valid && feed.ready;
    assign is_load    = accept && (feed.opcode == OP_LOAD);
    assign is_push    = accept && (feed.opcode == OP_SAMPLE);
    assign ld_ok      = (int'(feed.coef_phase) < PHASES) && (int'(feed.coef_tap) < TAPS);

    assign fill_inc   = (fill_reg == CW'(TAPS)) ? fill_reg : fill_reg + 1'b1;
    assign full_after = (fill_inc == CW'(TAPS));

    // whole datapath freezes while the output word is held
    assign adv   = !out_vld_reg || result.ready;
    assign issue = (state_reg == ST_RUN) && adv;

    assign tag0.phase = phase_reg;
    assign tag0.first = (ctap_reg == TW'(TAPS - 1));
    assign tag0.last  = (ctap_reg == '0);
    assign tag0.eof   = eof_reg;

    pfi_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (is_load && ld_ok),
        .waddr ({PW'(feed.coef_phase), TW'(feed.coef_tap)}),
        .wdata (feed.coef_value),
        .re    (issue),
        .raddr ({phase_reg, ctap_reg}),
        .rdata (coef_rdata)
    );

    // circular window: wr_ptr is the oldest slot once full
    pfi_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TAPS)
    ) u_win_ram (
        .clk   (clk),
        .we    (is_push),
        .waddr (wr_ptr_reg),
        .wdata (feed.sample_value),
        .re    (issue),
        .raddr (rd_ptr_reg),
        .rdata (win_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        phase_next  = phase_reg;
        ctap_next   = ctap_reg;
        eof_next    = eof_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_push)
                begin
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                    rd_ptr_next = ptr_inc(wr_ptr_reg);
                    fill_next   = feed.end_of_frame ? '0 : fill_inc;
                    if (full_after)
                    begin
                        state_next = ST_RUN;
                        phase_next = '0;
                        ctap_next  = TW'(TAPS - 1);
                        eof_next   = feed.end_of_frame;
                    end
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    if (ctap_reg == '0)
                    begin
                        ctap_next = TW'(TAPS - 1);
                        if (phase_reg == PW'(PHASES - 1))
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            phase_next = phase_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ctap_next = ctap_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            phase_reg  <= '0;
            ctap_reg   <= '0;
            eof_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            phase_reg  <= phase_next;
            ctap_reg   <= ctap_next;
            eof_reg    <= eof_next;
        end
    end

    assign acc_sum  = acc_reg + prod_reg;
    assign bias_sum = sum_reg + (sum_reg[DATA_W-1] ? Q15_BIAS : '0);
    assign quot     = {{Q15_SHIFT{bias_sum[DATA_W-1]}}, bias_sum[DATA_W-1:Q15_SHIFT]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_vld_reg  <= issue;
                s2_vld_reg  <= s1_vld_reg;
                s3_vld_reg  <= s2_vld_reg && s2_tag_reg.last;
                out_vld_reg <= s3_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg <= tag0;
            s2_tag_reg <= s1_tag_reg;
            prod_reg   <= coef_rdata * win_rdata;
            s3_tag_reg <= s2_tag_reg;
            if (s2_vld_reg)
            begin
                acc_reg <= s2_tag_reg.first ? prod_reg : acc_sum;
            end
            sum_reg <= acc_sum;
            if (s3_vld_reg)
            begin
                out_sample_reg <= quot;
                out_phase_reg  <= s3_tag_reg.phase;
                out_last_reg   <= (s3_tag_reg.phase == PW'(PHASES - 1));
                out_eof_reg    <= (s3_tag_reg.phase == PW'(PHASES - 1)) && s3_tag_reg.eof;
            end
        end
    end

    assign result.valid         = out_vld_reg;
    assign result.out_sample    = out_sample_reg;
    assign result.out_phase     = PHASE_FIELD_W'(out_phase_reg);
    assign result.last_of_run   = out_last_reg;
    assign result.last_of_frame = out_eof_reg;

endmodule

FILE: design/pfi_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfi_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module pfi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/pfi_checker.sv
`timescale 1ns / 1ps
`include "polyphase_fir_interpolator_core_defines.svh"
// ---------------------------------------------------------------------------
// pfi_checker
// Port-level checks on the polyphase FIR interpolator, bound to the core.
// ---------------------------------------------------------------------------
module pfi_checker #(
    parameter int PHASES = pfi_pkg::DEF_PHASES
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                feed_valid,
    input logic                                feed_ready,
    input logic                                feed_opcode,
    input logic                                result_valid,
    input logic                                result_ready,
    input logic [pfi_pkg::PHASE_FIELD_W-1:0]   out_phase,
    input logic                                last_of_run,
    input logic                                last_of_frame
);
    import pfi_pkg::*;

    `PFI_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid, "output word dropped while stalled")
    `PFI_ASSERT_NOW(a_frame_on_run, result_valid && last_of_frame, last_of_run, "frame end without run end")
    `PFI_ASSERT_NOW(a_run_end_phase, result_valid && last_of_run, out_phase == PHASE_FIELD_W'(PHASES - 1), "run end on wrong phase")
    `PFI_ASSERT_NEXT(a_load_single, feed_valid && feed_ready && feed_opcode == OP_LOAD, feed_ready, "load word blocked the input")

endmodule

bind polyphase_fir_interpolator_core pfi_checker #(
    .PHASES (PHASES)
) u_pfi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .feed_valid    (feed.valid),
    .feed_ready    (feed.ready),
    .feed_opcode   (feed.opcode),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .out_phase     (result.out_phase),
    .last_of_run   (result.last_of_run),
    .last_of_frame (result.last_of_frame)
);
